// ===== rtl/fpsm_pkg.sv =====
package fpsm_pkg;

    // field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int OPND_W      = SAMPLE_W + 1;
    localparam int PROD_W      = OPND_W + COEF_W;
    localparam int RESULT_W    = 36;
    localparam int COLS_REG_W  = 11;
    localparam int ROWS_REG_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    // grid size limits and reset dimensions
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 65535;
    localparam int DIM_RESET    = 1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTRE = 3'd0,
        REG_ROW    = 3'd1,
        REG_COLUMN = 3'd2,
        REG_COLS   = 3'd3,
        REG_ROWS   = 3'd4
    } cfg_reg_t;

    // stencil coefficients
    typedef struct packed {
        logic signed [COEF_W-1:0] centre;
        logic signed [COEF_W-1:0] row;
        logic signed [COEF_W-1:0] column;
    } coef_t;

    // one multiply-add job: operand per coefficient plus output flags
    typedef struct packed {
        logic signed [OPND_W-1:0] xa;
        logic signed [OPND_W-1:0] xb;
        logic signed [OPND_W-1:0] xg;
        logic                     last;
        logic                     done;
    } job_t;

endpackage

// ===== rtl/fpsm_ram.sv =====
module fpsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port, read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fpsm_mac.sv =====
module fpsm_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             job_valid,
    input  fpsm_pkg::job_t                   job,
    input  fpsm_pkg::coef_t                  coef,
    output logic                             job_ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fpsm_pkg::OUT_TDATA_W-1:0] m_tdata,  // product[35:0], zero fill
    output logic                             m_tlast,  // last_in_run
    output logic                             m_tuser   // grid_done
);

    import fpsm_pkg::*;

    logic                     mul_v_reg, mul_v_next;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pg_reg;
    logic signed [PROD_W-1:0] pa_next, pb_next, pg_next;
    logic                     mul_last_reg, mul_done_reg;
    logic                     out_v_reg, out_v_next;
    logic [RESULT_W-1:0]      out_sum_reg, out_sum_next;
    logic                     out_last_reg, out_done_reg;
    logic signed [PROD_W+1:0] sum_full;
    logic                     out_en;
    logic                     mul_en;

    // stage enables: a stage moves when the one after it is empty or moving
    assign out_en    = !out_v_reg || m_tready;
    assign mul_en    = !mul_v_reg || out_en;
    assign job_ready = mul_en;

    // multiplier stage
    assign pa_next = PROD_W'(job.xa) * PROD_W'(coef.centre);
    assign pb_next = PROD_W'(job.xb) * PROD_W'(coef.row);
    assign pg_next = PROD_W'(job.xg) * PROD_W'(coef.column);

    // sum stage, kept to the result width
    assign sum_full     = (PROD_W+2)'(pa_reg) + (PROD_W+2)'(pb_reg) + (PROD_W+2)'(pg_reg);
    assign out_sum_next = sum_full[RESULT_W-1:0];

    always_comb
    begin
        mul_v_next = mul_v_reg;
        out_v_next = out_v_reg;
        if (mul_en)
        begin
            mul_v_next = job_valid;
        end
        if (out_en)
        begin
            out_v_next = mul_v_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            mul_v_reg <= mul_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (mul_en && job_valid)
        begin
            pa_reg       <= pa_next;
            pb_reg       <= pb_next;
            pg_reg       <= pg_next;
            mul_last_reg <= job.last;
            mul_done_reg <= job.done;
        end
        if (out_en && mul_v_reg)
        begin
            out_sum_reg  <= out_sum_next;
            out_last_reg <= mul_last_reg;
            out_done_reg <= mul_done_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_sum_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

// ===== rtl/five_point_stencil_matvec_top.sv =====
// Five-point stencil matrix-vector product over a grid streamed in raster order.
// One sample is taken per cycle unless the output stalls; a sample of the last row
// causes up to two results (up to three for the grid's final sample), and since all
// results share one three-multiplier multiply-add unit such a sample occupies one
// cycle per result. Each result passes the read stage register, then the multiplier
// and sum registers of the multiply-add unit, before it is presented. The two
// previous rows live in two line RAMs (one per row parity, one read and one
// write per item); the next column is prefetched as each sample is accepted.
// Writing grid_cols or grid_rows restarts the grid at its first point; no
// clearing pass is needed after reset.
module five_point_stencil_matvec_top #(
    parameter int MAX_COLS = fpsm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = fpsm_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fpsm_pkg::IN_TDATA_W-1:0]  s_tdata,   // sample[15:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fpsm_pkg::OUT_TDATA_W-1:0] m_tdata,   // product[35:0], zero fill
    output logic                             m_tlast,   // last_in_run
    output logic                             m_tuser,   // grid_done
    input  logic                             cfg_we,
    input  logic [fpsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import fpsm_pkg::*;

    localparam int CW       = $clog2(MAX_COLS);
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int COLS_RST = (DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET;
    localparam int ROWS_RST = (DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET;
    localparam int JOB_A    = 0;
    localparam int JOB_B    = 1;
    localparam int JOB_C    = 2;

    // position flags of the sample in the read stage
    typedef struct packed {
        logic bank;
        logic fwd;
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic c_mid;
    } pos_flags_t;

    // configuration
    coef_t          coef_reg, coef_next;
    logic [CW-1:0]  cols_last_reg, cols_last_next;
    logic [RW-1:0]  rows_last_reg, rows_last_next;
    logic           restart;
    logic [COLS_REG_W-1:0] cols_val;
    logic [ROWS_REG_W-1:0] rows_val;

    // position of the next sample
    logic [CW-1:0]  col_pos_reg, col_pos_next;
    logic [RW-1:0]  row_pos_reg, row_pos_next;

    // read stage
    logic                       s1_v_reg, s1_v_next;
    logic [2:0]                 s1_jobs_reg, s1_jobs_next;
    pos_flags_t                 s1_pos_reg, s1_pos_next;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic signed [SAMPLE_W-1:0] p1_reg, p2_reg;
    logic signed [SAMPLE_W-1:0] win_c_reg [2];
    logic signed [SAMPLE_W-1:0] win_m_reg [2];
    logic signed [SAMPLE_W-1:0] rd_eff [2];
    logic [SAMPLE_W-1:0]        rdata0, rdata1;

    logic                       accept;
    logic                       issue;
    logic                       s1_done;
    logic                       last_row;
    logic                       c_last;
    logic [CW-1:0]              raddr;
    logic                       nb;
    job_t                       job;
    logic                       job_ready;

    // ------------------------------------------------------------------
    // configuration writes, dimensions kept as clamped last indexes
    // ------------------------------------------------------------------
    assign cols_val = cfg_data[COLS_REG_W-1:0];
    assign rows_val = cfg_data[ROWS_REG_W-1:0];

    always_comb
    begin
        coef_next      = coef_reg;
        cols_last_next = cols_last_reg;
        rows_last_next = rows_last_reg;
        restart        = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTRE: coef_next.centre = cfg_data[COEF_W-1:0];
                REG_ROW:    coef_next.row    = cfg_data[COEF_W-1:0];
                REG_COLUMN: coef_next.column = cfg_data[COEF_W-1:0];
                REG_COLS:
                begin
                    restart = 1'b1;
                    if (cols_val == '0)
                        cols_last_next = '0;
                    else if (int'(cols_val) > MAX_COLS)
                        cols_last_next = CW'(MAX_COLS - 1);
                    else
                        cols_last_next = CW'(int'(cols_val) - 1);
                end
                REG_ROWS:
                begin
                    restart = 1'b1;
                    if (rows_val == '0)
                        rows_last_next = '0;
                    else if (int'(rows_val) > MAX_ROWS)
                        rows_last_next = RW'(MAX_ROWS - 1);
                    else
                        rows_last_next = RW'(int'(rows_val) - 1);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input handshake and position
    // ------------------------------------------------------------------
    assign issue    = s1_v_reg && (s1_jobs_reg != '0) && job_ready;
    assign s1_done  = s1_v_reg && ((s1_jobs_reg == '0) ||
                      (job_ready && ((s1_jobs_reg & (s1_jobs_reg - 3'd1)) == '0)));
    assign s_tready = !s1_v_reg || s1_done;
    assign accept   = s_tvalid && s_tready;

    assign last_row = (row_pos_reg == rows_last_reg);
    assign c_last   = (col_pos_reg == cols_last_reg);
    assign raddr    = c_last ? '0 : col_pos_reg + CW'(1);

    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (restart)
        begin
            col_pos_next = '0;
            row_pos_next = '0;
        end
        else if (accept)
        begin
            if (c_last)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + RW'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // read stage control: pending results of the current sample
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_pos_next.bank  = row_pos_reg[0];
        s1_pos_next.fwd   = (cols_last_reg == '0);
        s1_pos_next.r_ge1 = (row_pos_reg != '0);
        s1_pos_next.r_ge2 = (row_pos_reg > RW'(1));
        s1_pos_next.c_ge1 = (col_pos_reg != '0);
        s1_pos_next.c_ge2 = (col_pos_reg > CW'(1));
        s1_pos_next.c_mid = !c_last;

        s1_v_next    = s1_v_reg;
        s1_jobs_next = s1_jobs_reg;
        if (accept)
        begin
            s1_v_next           = 1'b1;
            s1_jobs_next[JOB_A] = (row_pos_reg != '0);
            s1_jobs_next[JOB_B] = last_row && (col_pos_reg != '0);
            s1_jobs_next[JOB_C] = last_row && c_last;
        end
        else
        begin
            if (s1_done)
            begin
                s1_v_next = 1'b0;
            end
            if (issue)
            begin
                s1_jobs_next = s1_jobs_reg & (s1_jobs_reg - 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg      <= '0;
            cols_last_reg <= CW'(COLS_RST - 1);
            rows_last_reg <= RW'(ROWS_RST - 1);
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            s1_v_reg      <= 1'b0;
            s1_jobs_reg   <= '0;
        end
        else
        begin
            coef_reg      <= coef_next;
            cols_last_reg <= cols_last_next;
            rows_last_reg <= rows_last_next;
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            s1_v_reg      <= s1_v_next;
            s1_jobs_reg   <= s1_jobs_next;
        end
    end

    // ------------------------------------------------------------------
    // line RAMs, one per row parity
    // ------------------------------------------------------------------
    fpsm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_COLS)
    ) u_ram_even (
        .clk   (clk),
        .we    (accept && !row_pos_reg[0]),
        .waddr (col_pos_reg),
        .wdata (s_tdata[SAMPLE_W-1:0]),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata0)
    );

    fpsm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_COLS)
    ) u_ram_odd (
        .clk   (clk),
        .we    (accept && row_pos_reg[0]),
        .waddr (col_pos_reg),
        .wdata (s_tdata[SAMPLE_W-1:0]),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata1)
    );

    // single-column grid reads the entry written in the same cycle
    always_comb
    begin
        rd_eff[0] = rdata0;
        rd_eff[1] = rdata1;
        if (s1_pos_reg.fwd)
        begin
            rd_eff[s1_pos_reg.bank] = s1_sample_reg;
        end
    end

    // sample history, column window of the two stored rows
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= s_tdata[SAMPLE_W-1:0];
            s1_pos_reg    <= s1_pos_next;
            p1_reg        <= s1_sample_reg;
            p2_reg        <= p1_reg;
        end
        if (s1_done)
        begin
            win_c_reg[0] <= rd_eff[0];
            win_c_reg[1] <= rd_eff[1];
            win_m_reg[0] <= win_c_reg[0];
            win_m_reg[1] <= win_c_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // job operands: lower neighbour done, last-row left point, final point
    // ------------------------------------------------------------------
    assign nb = !s1_pos_reg.bank;

    always_comb
    begin
        job.last = ((s1_jobs_reg & (s1_jobs_reg - 3'd1)) == '0);
        job.done = 1'b0;
        if (s1_jobs_reg[JOB_A])
        begin
            job.xa = OPND_W'(win_c_reg[nb]);
            job.xg = OPND_W'(s1_sample_reg)
                   + (s1_pos_reg.r_ge2 ? OPND_W'(win_c_reg[s1_pos_reg.bank]) : '0);
            job.xb = (s1_pos_reg.c_ge1 ? OPND_W'(win_m_reg[nb]) : '0)
                   + (s1_pos_reg.c_mid ? OPND_W'(rd_eff[nb]) : '0);
        end
        else if (s1_jobs_reg[JOB_B])
        begin
            job.xa = OPND_W'(p1_reg);
            job.xb = OPND_W'(s1_sample_reg)
                   + (s1_pos_reg.c_ge2 ? OPND_W'(p2_reg) : '0);
            job.xg = s1_pos_reg.r_ge1 ? OPND_W'(win_m_reg[nb]) : '0;
        end
        else
        begin
            job.done = 1'b1;
            job.xa   = OPND_W'(s1_sample_reg);
            job.xb   = s1_pos_reg.c_ge1 ? OPND_W'(p1_reg) : '0;
            job.xg   = s1_pos_reg.r_ge1 ? OPND_W'(win_c_reg[nb]) : '0;
        end
    end

    // ------------------------------------------------------------------
    // multiply-add unit and output register
    // ------------------------------------------------------------------
    fpsm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (s1_v_reg && (s1_jobs_reg != '0)),
        .job       (job),
        .coef      (coef_reg),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("grid end result not marked as last of its item");

    a_hold_multi: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && ($countones(s1_jobs_reg) > 1) |-> !s_tready)
        else $error("item taken while several results still pending");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && ((cfg_index == REG_COLS) || (cfg_index == REG_ROWS))
        |=> (col_pos_reg == '0) && (row_pos_reg == '0))
        else $error("grid not restarted after dimension write");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpsm_pkg::*;

    localparam int     MAX_COLS      = DEF_MAX_COLS;
    localparam int     MAX_ROWS      = DEF_MAX_ROWS;
    // settling wait that covers any work still in flight
    localparam int     SETTLE        = 12;
    localparam int     CHOKE_LEN     = 600;
    localparam int     RANDOM_ITEMS  = 72;
    localparam int     PRESSURE_COLS = 8;
    localparam int     PRESSURE_ROWS = 3;
    localparam longint CYCLE_LIMIT   = 400000;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    typedef struct packed {
        logic signed [RESULT_W-1:0] product;
        logic                       last_in_run;
        logic                       grid_done;
    } point_result_t;

    typedef enum logic {STEP_WRITE, STEP_SAMPLE} step_kind_t;

    typedef struct packed {
        step_kind_t                 kind;
        logic [CFG_IDX_W-1:0]       index;
        logic [CFG_DATA_W-1:0]      value;
        logic                       pinned;
        logic signed [RESULT_W-1:0] product;
    } script_entry_t;

    // directed stimulus; a pinned row fixes the product of the item's last result
    localparam int SCRIPT_LEN = 41;
    localparam script_entry_t SCRIPT [0:SCRIPT_LEN-1] = '{
        // zero coefficients after reset, first row of the default grid gives nothing
        '{STEP_SAMPLE, '0,         18'h07FFF, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h08000, 1'b0, 36'sd0},
        // single column, two rows, extreme coefficients
        '{STEP_WRITE,  REG_CENTRE, 18'h1FFFF, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_ROW,    18'h20000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_COLUMN, 18'h01000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_COLS,   18'h00000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_ROWS,   18'h00002, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_SPARE,  18'h3FFFF, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h08000, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h07FFF, 1'b1, 36'sd4160585729},
        // one-point grid: every item is a whole grid
        '{STEP_WRITE,  REG_CENTRE, 18'h20000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_ROW,    18'h20000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_COLUMN, 18'h20000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_ROWS,   18'h00000, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h08000, 1'b1, 36'sd4294967296},
        '{STEP_SAMPLE, '0,         18'h07FFF, 1'b1, -36'sd4294836224},
        '{STEP_SAMPLE, '0,         18'h00000, 1'b1, 36'sd0},
        // single row of four
        '{STEP_WRITE,  REG_CENTRE, 18'h04000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_ROW,    18'h3F000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_COLUMN, 18'h3F000, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_COLS,   18'h00004, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h00100, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h0FF00, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h01234, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h08000, 1'b0, 36'sd0},
        // 3x3 grid broken off after four items, then restarted by a dimension write
        '{STEP_WRITE,  REG_ROWS,   18'h00003, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_COLS,   18'h00003, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h0FFFF, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h00001, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h07FFF, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h0ABCD, 1'b0, 36'sd0},
        '{STEP_WRITE,  REG_COLS,   18'h00003, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h08000, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h07FFF, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h00000, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h0FFFF, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h00001, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h05555, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h0AAAA, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h08001, 1'b0, 36'sd0},
        '{STEP_SAMPLE, '0,         18'h07FFE, 1'b0, 36'sd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // own copy of the stencil state and registers
    logic signed [SAMPLE_W-1:0] line_copy [0:2*MAX_COLS-1];
    int unsigned                next_col;
    int unsigned                next_row;
    logic signed [COEF_W-1:0]   centre_q;
    logic signed [COEF_W-1:0]   row_q;
    logic signed [COEF_W-1:0]   column_q;
    logic [COLS_REG_W-1:0]      cols_q;
    logic [ROWS_REG_W-1:0]      rows_q;

    point_result_t awaited_points [$];
    int            fault_count;
    bit            sender_burst;
    bit            sender_quiet;
    bit            sink_burst;
    bit            choke_request;

    five_point_stencil_matvec_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clamped grid dimensions
    function automatic int unsigned active_cols();
        if (cols_q == 0)
            return 1;
        if (cols_q > MAX_COLS)
            return MAX_COLS;
        return cols_q;
    endfunction

    function automatic int unsigned active_rows();
        if (rows_q == 0)
            return 1;
        if (rows_q > MAX_ROWS)
            return MAX_ROWS;
        return rows_q;
    endfunction

    // one bank per row parity
    function automatic int line_slot(input int unsigned r, input int unsigned c);
        return int'(r & 1) * MAX_COLS + int'(c % MAX_COLS);
    endfunction

    // stencil products completed by one sample, queued in output order
    function automatic int stencil_predict(input logic signed [SAMPLE_W-1:0] sample);
        int unsigned   cols;
        int unsigned   rows;
        int unsigned   r;
        int unsigned   c;
        longint        a;
        longint        b;
        longint        g;
        longint        s;
        longint        sum;
        point_result_t found [0:2];
        int            n;
        int            k;
        cols = active_cols();
        rows = active_rows();
        r = next_row;
        c = next_col;
        n = 0;
        if (r >= rows || c >= cols)
        begin
            r = 0;
            c = 0;
        end
        a = centre_q;
        b = row_q;
        g = column_q;
        s = sample;

        // point above is complete once its lower neighbour arrives
        if (r >= 1)
        begin
            sum = a * line_copy[line_slot(r - 1, c)] + g * s;
            if (r >= 2)
                sum += g * line_copy[line_slot(r - 2, c)];
            if (c >= 1)
                sum += b * line_copy[line_slot(r - 1, c - 1)];
            if (c + 1 < cols)
                sum += b * line_copy[line_slot(r - 1, c + 1)];
            found[n] = '{product: sum[RESULT_W-1:0], last_in_run: 1'b0, grid_done: 1'b0};
            n++;
        end

        line_copy[line_slot(r, c)] = sample;

        if (r == rows - 1)
        begin
            // last row: left point waits only for its right neighbour
            if (c >= 1)
            begin
                sum = a * line_copy[line_slot(r, c - 1)] + b * s;
                if (c >= 2)
                    sum += b * line_copy[line_slot(r, c - 2)];
                if (r >= 1)
                    sum += g * line_copy[line_slot(r - 1, c - 1)];
                found[n] = '{product: sum[RESULT_W-1:0], last_in_run: 1'b0, grid_done: 1'b0};
                n++;
            end
            // final point of the grid goes out with its own sample
            if (c == cols - 1)
            begin
                sum = a * s;
                if (c >= 1)
                    sum += b * line_copy[line_slot(r, c - 1)];
                if (r >= 1)
                    sum += g * line_copy[line_slot(r - 1, c)];
                found[n] = '{product: sum[RESULT_W-1:0], last_in_run: 1'b0, grid_done: 1'b1};
                n++;
            end
        end

        if (n > 0)
            found[n - 1].last_in_run = 1'b1;
        for (k = 0; k < n; k++)
            awaited_points.push_back(found[k]);

        // raster advance, wrapping to a new grid
        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end
        next_col = c;
        next_row = r;
        return n;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coeff();
        logic [31:0] raw;
        raw = $urandom();
        case (raw[31:29])
            3'd0: return 18'h1FFFF;
            3'd1: return 18'h20000;
            3'd2: return 18'h01000;
            default: return raw[CFG_DATA_W-1:0];
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [31:0] raw;
        raw = $urandom();
        case (raw[31:29])
            3'd0: return 16'h7FFF;
            3'd1: return 16'h8000;
            default: return raw[SAMPLE_W-1:0];
        endcase
    endfunction

    // register write, applied to the local copy at the same edge
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_CENTRE: centre_q = value;
            REG_ROW:    row_q = value;
            REG_COLUMN: column_q = value;
            REG_COLS:
            begin
                cols_q   = value[COLS_REG_W-1:0];
                next_col = 0;
                next_row = 0;
            end
            REG_ROWS:
            begin
                rows_q   = value[ROWS_REG_W-1:0];
                next_col = 0;
                next_row = 0;
            end
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one item after a random gap and predict it once taken
    task automatic offer_sample(input logic [SAMPLE_W-1:0] sample, output int produced);
        int gap;
        if ($urandom_range(0, 15) == 0)
            sender_burst = !sender_burst;
        gap = (sender_burst || sender_quiet) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge clk); while (!s_tready);
        produced = stencil_predict(sample);
    endtask

    // wait out every awaited result plus the pipeline
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (awaited_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int                         stall;
        int                         held;
        point_result_t              want;
        logic signed [RESULT_W-1:0] got;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (choke_request)
            begin
                choke_request = 1'b0;
                m_tready <= 1'b0;
                held = 0;
                while (held < CHOKE_LEN)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            if ($urandom_range(0, 15) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = m_tdata[RESULT_W-1:0];
            if (awaited_points.size() == 0)
            begin
                $error("result item with nothing awaited: product %0d", got);
                fault_count++;
            end
            else
            begin
                want = awaited_points.pop_front();
                if (got !== want.product)
                begin
                    $error("product: expected %0d, got %0d", want.product, got);
                    fault_count++;
                end
                if (m_tlast !== want.last_in_run)
                begin
                    $error("last_in_run: expected %0b, got %0b", want.last_in_run, m_tlast);
                    fault_count++;
                end
                if (m_tuser !== want.grid_done)
                begin
                    $error("grid_done: expected %0b, got %0b", want.grid_done, m_tuser);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int                    i;
        int                    produced;
        int                    phase;
        int                    random_sent;
        int                    count;
        longint                points_left;
        script_entry_t         entry;
        point_result_t         tail;
        logic [CFG_DATA_W-1:0] cols_pick;
        logic [CFG_DATA_W-1:0] rows_pick;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        fault_count   = 0;
        sender_burst  = 1'b0;
        sender_quiet  = 1'b0;
        sink_burst    = 1'b0;
        choke_request = 1'b0;
        centre_q = '0;
        row_q    = '0;
        column_q = '0;
        cols_q   = COLS_REG_W'(DIM_RESET);
        rows_q   = ROWS_REG_W'(DIM_RESET);
        next_col = 0;
        next_row = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < SCRIPT_LEN; i++)
        begin
            entry = SCRIPT[i];
            if (entry.kind == STEP_WRITE)
            begin
                if (i > 0 && SCRIPT[i - 1].kind == STEP_SAMPLE)
                    drain_block();
                write_register(entry.index, entry.value);
            end
            else
            begin
                offer_sample(entry.value[SAMPLE_W-1:0], produced);
                if (entry.pinned && produced > 0)
                begin
                    tail = awaited_points.pop_back();
                    tail.product = entry.product;
                    awaited_points.push_back(tail);
                end
            end
        end

        // small grid; the receiver holds off while the rows after the first stream in
        drain_block();
        write_register(REG_CENTRE, random_coeff());
        write_register(REG_ROW, random_coeff());
        write_register(REG_COLUMN, random_coeff());
        write_register(REG_COLS, CFG_DATA_W'(PRESSURE_COLS));
        write_register(REG_ROWS, CFG_DATA_W'(PRESSURE_ROWS));
        repeat (PRESSURE_COLS) offer_sample(random_sample(), produced);
        sender_quiet  = 1'b1;
        choke_request = 1'b1;
        repeat (PRESSURE_COLS * (PRESSURE_ROWS - 1)) offer_sample(random_sample(), produced);
        sender_quiet  = 1'b0;

        // random phases: mostly whole small grids, some broken off or run past the end
        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain_block();
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_register(REG_CENTRE, random_coeff());
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_register(REG_ROW, random_coeff());
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_register(REG_COLUMN, random_coeff());
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: cols_pick = '0;
                    1: cols_pick = CFG_DATA_W'(1);
                    2: cols_pick = CFG_DATA_W'(2047);
                    3: cols_pick = CFG_DATA_W'(MAX_COLS);
                    default: cols_pick = CFG_DATA_W'($urandom_range(2, 8));
                endcase
                case ($urandom_range(0, 7))
                    0: rows_pick = '0;
                    1: rows_pick = CFG_DATA_W'(1);
                    2: rows_pick = CFG_DATA_W'(MAX_ROWS);
                    default: rows_pick = CFG_DATA_W'($urandom_range(2, 6));
                endcase
                write_register(REG_COLS, cols_pick);
                write_register(REG_ROWS, rows_pick);
            end
            if ($urandom_range(0, 9) == 0)
                write_register(REG_SPARE, random_coeff());

            points_left = longint'(active_cols()) * active_rows()
                          - (longint'(next_row) * active_cols() + next_col);
            if (points_left <= 64 && $urandom_range(0, 3) != 0)
            begin
                count = int'(points_left);
                if ($urandom_range(0, 3) == 0)
                    count += $urandom_range(1, 3);
            end
            else
                count = $urandom_range(1, 24);

            repeat (count)
            begin
                offer_sample(random_sample(), produced);
                random_sent++;
            end
            phase++;
        end

        drain_block();
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
